[hw/rtl/saa_pkg.sv]
// Package for the slab arena allocator: sizing constants, command and
// status codes, sequencer states and the structs shared by all modules.
// No dependencies.
`default_nettype none

package saa_pkg;

  // Sizing
  localparam int unsigned SLAB_BYTES = 65536;
  localparam int unsigned MAX_SLABS  = 16;
  localparam int unsigned POOL_UNITS = 256;

  localparam int unsigned SB_LOG = $clog2(SLAB_BYTES);
  localparam int unsigned IDX_W  = $clog2(MAX_SLABS);
  localparam int unsigned CNT_W  = $clog2(MAX_SLABS + 1);
  localparam int unsigned UNIT_W = $clog2(POOL_UNITS + 1);
  localparam int unsigned FILL_W = UNIT_W + SB_LOG;
  localparam int unsigned TOT_W  = 25;
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned SIZE_W = 24;
  // datapath width: covers a 2^31 alignment mask plus pool addresses
  localparam int unsigned DW     = 34;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_REALLOC = 3'd2,
    CMD_RESET   = 3'd3,
    CMD_TRIM    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_EXHAUST = 2'd1,
    STS_MARK    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NOP,
    S_AL_UN,
    S_AL_AL,
    S_AL_PAD,
    S_AL_NEED,
    S_AL_REM,
    S_AL_CMP,
    S_AL_FNEW,
    S_AL_TOT,
    S_AL_SWEEP,
    S_AL_SKIP,
    S_AL_WORST,
    S_AL_UNITS,
    S_AL_POOL,
    S_DA_TOP,
    S_DA_END,
    S_DA_FS,
    S_DA_TOT,
    S_RA_TOP,
    S_RA_END,
    S_RA_FO,
    S_RA_NF,
    S_RA_CAP,
    S_RA_TOT,
    S_RA_TOT2,
    S_RS_REM,
    S_RS_CMP,
    S_RS_DROP,
    S_TRIM
  } state_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] prev_size;
    logic [4:0]        align_log2;
    logic [ADDR_W-1:0] block_addr;
    logic [TOT_W-1:0]  mark;
  } cmd_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              moved;
    logic [SIZE_W-1:0] copy_len;
    logic [TOT_W-1:0]  total_fill;
    logic [1:0]        status;
  } res_word_t;

  // shared adder/subtractor operation
  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          sub;
  } alu_op_t;

  // slab table read data
  typedef struct packed {
    logic [UNIT_W-1:0] base;
    logic [UNIT_W-1:0] units;
    logic [FILL_W-1:0] fill;
  } slab_rd_t;

  // slab table write request
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              we_fill;
    logic [FILL_W-1:0] fill;
    logic              we_slab;
    logic [UNIT_W-1:0] base;
    logic [UNIT_W-1:0] units;
  } slab_wr_t;

endpackage

`default_nettype wire

[hw/rtl/saa_alu.sv]
// Shared add/subtract unit of the slab arena allocator.
// Depends on saa_pkg.
`default_nettype none

module saa_alu (
  input  saa_pkg::alu_op_t            op_i,
  output logic [saa_pkg::DW-1:0]      y_o,
  output logic                        ge_o
);

  logic [saa_pkg::DW-1:0] b_x;
  logic [saa_pkg::DW:0]   sum;

  // subtract as a + ~b + 1; carry out means a >= b
  assign b_x  = op_i.sub ? ~op_i.b : op_i.b;
  assign sum  = {1'b0, op_i.a} + {1'b0, b_x} + (saa_pkg::DW + 1)'(op_i.sub);
  assign y_o  = sum[saa_pkg::DW-1:0];
  assign ge_o = sum[saa_pkg::DW];

endmodule

`default_nettype wire

[hw/rtl/saa_table.sv]
// Slab table of the slab arena allocator: base, capacity and fill per slab,
// one read index and one write port. Depends on saa_pkg.
`default_nettype none

module saa_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [saa_pkg::IDX_W-1:0]     rd_idx_i,
  output saa_pkg::slab_rd_t             rd_o,
  input  saa_pkg::slab_wr_t             wr_i
);

  logic [saa_pkg::UNIT_W-1:0] base_q  [saa_pkg::MAX_SLABS];
  logic [saa_pkg::UNIT_W-1:0] units_q [saa_pkg::MAX_SLABS];
  logic [saa_pkg::FILL_W-1:0] fill_q  [saa_pkg::MAX_SLABS];

  // capacity and fill: cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(saa_pkg::MAX_SLABS); i++) begin
        units_q[i] <= '0;
        fill_q[i]  <= '0;
      end
    end else begin
      if (wr_i.we_slab) begin
        units_q[wr_i.idx] <= wr_i.units;
      end
      if (wr_i.we_fill) begin
        fill_q[wr_i.idx] <= wr_i.fill;
      end
    end
  end

  // base: written when a slab is created
  always_ff @(posedge clk_i) begin
    if (wr_i.we_slab) begin
      base_q[wr_i.idx] <= wr_i.base;
    end
  end

  // the empty slab sits at pool unit zero; its base and capacity are never written
  assign rd_o.base  = (rd_idx_i == '0) ? '0 : base_q[rd_idx_i];
  assign rd_o.units = units_q[rd_idx_i];
  assign rd_o.fill  = fill_q[rd_idx_i];

endmodule

`default_nettype wire

[hw/rtl/slab_arena_allocator_top.sv]
// Slab arena allocator top level: command sequencer around one shared adder.
// Depends on saa_pkg, saa_alu and saa_table.
//
// A command word is taken when start is high and busy is low; busy then stays
// high until the result word is shown for one cycle with done_o, which the
// receiver must take in that cycle. Arithmetic steps go through the single
// 34-bit adder, one operation per cycle. Allocate tries the current slab and
// those above it, creates new slabs at the pool top when none fits and writes
// the skipped slabs back as full; reallocate resolves in place, keeps the block
// or falls into allocate; reset to mark walks slabs back, and stops at once
// when the mark is above the total. The next command can be taken in the same
// cycle as done_o.
`default_nettype none

module slab_arena_allocator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  saa_pkg::cmd_word_t  cmd_i,
  output logic                done_o,
  output saa_pkg::res_word_t  res_o
);

  localparam int unsigned DW = saa_pkg::DW;

  saa_pkg::state_e state_q, state_d;
  saa_pkg::cmd_word_t req_q, req_d;
  saa_pkg::res_word_t res_q, res_d;
  logic done_q, done_d;

  // architectural state
  logic [saa_pkg::IDX_W-1:0]  cur_q, cur_d;
  logic [saa_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [saa_pkg::TOT_W-1:0]  tot_q, tot_d;
  logic [saa_pkg::UNIT_W-1:0] pnu_q, pnu_d;

  // working registers
  logic [saa_pkg::IDX_W-1:0]  w_q, w_d, sw_q, sw_d;
  logic [saa_pkg::TOT_W-1:0]  t_q, t_d;
  logic [DW-1:0]              ra_q, ra_d, rb_q, rb_d, rc_q, rc_d, rd_q, rd_d;
  logic                       ge1_q, ge1_d, ge2_q, ge2_d, first_q, first_d;
  logic                       realloc_q, realloc_d;

  saa_pkg::alu_op_t  alu;
  logic [DW-1:0]     alu_y;
  logic              alu_ge;
  saa_pkg::slab_rd_t rd;
  saa_pkg::slab_wr_t tw;
  logic [saa_pkg::IDX_W-1:0] rd_idx;

  logic [DW-1:0] mask, st, cap, fl, blk, sz, osz;
  logic          aligned;

  saa_alu u_alu (
    .op_i (alu),
    .y_o  (alu_y),
    .ge_o (alu_ge)
  );

  saa_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (tw)
  );

  // operand views of the latched command and the selected slab
  assign mask    = ~({DW{1'b1}} << req_q.align_log2);
  assign st      = DW'({rd.base, {saa_pkg::SB_LOG{1'b0}}});
  assign cap     = DW'({rd.units, {saa_pkg::SB_LOG{1'b0}}});
  assign fl      = DW'(rd.fill);
  assign blk     = DW'(req_q.block_addr);
  assign sz      = DW'(req_q.size);
  assign osz     = DW'(req_q.prev_size);
  assign aligned = ((blk & mask) == '0);
  assign rd_idx  = (state_q == saa_pkg::S_AL_SWEEP) ? sw_q : w_q;

  // state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= saa_pkg::S_IDLE;
      done_q    <= 1'b0;
      cur_q     <= '0;
      cnt_q     <= saa_pkg::CNT_W'(1);
      tot_q     <= '0;
      pnu_q     <= '0;
      w_q       <= '0;
      sw_q      <= '0;
      first_q   <= 1'b0;
      realloc_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      cur_q     <= cur_d;
      cnt_q     <= cnt_d;
      tot_q     <= tot_d;
      pnu_q     <= pnu_d;
      w_q       <= w_d;
      sw_q      <= sw_d;
      first_q   <= first_d;
      realloc_q <= realloc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    t_q   <= t_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    rc_q  <= rc_d;
    rd_q  <= rd_d;
    ge1_q <= ge1_d;
    ge2_q <= ge2_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    done_d    = 1'b0;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    tot_d     = tot_q;
    pnu_d     = pnu_q;
    w_d       = w_q;
    sw_d      = sw_q;
    t_d       = t_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    rc_d      = rc_q;
    rd_d      = rd_q;
    ge1_d     = ge1_q;
    ge2_d     = ge2_q;
    first_d   = first_q;
    realloc_d = realloc_q;
    alu       = '0;
    tw        = '0;
    tw.idx    = w_q;

    case (state_q)
      saa_pkg::S_IDLE: begin
        if (start) begin
          req_d     = cmd_i;
          res_d     = '0;
          w_d       = cur_q;
          sw_d      = cur_q;
          t_d       = tot_q;
          first_d   = 1'b1;
          realloc_d = 1'b0;
          case (cmd_i.cmd)
            saa_pkg::CMD_ALLOC:   state_d = saa_pkg::S_AL_UN;
            saa_pkg::CMD_FREE:    state_d = saa_pkg::S_DA_TOP;
            saa_pkg::CMD_REALLOC: state_d = saa_pkg::S_RA_TOP;
            saa_pkg::CMD_RESET:   state_d = saa_pkg::S_RS_REM;
            saa_pkg::CMD_TRIM:    state_d = saa_pkg::S_TRIM;
            default:              state_d = saa_pkg::S_NOP;
          endcase
        end
      end

      saa_pkg::S_NOP: begin
        done_d  = 1'b1;
        state_d = saa_pkg::S_IDLE;
      end

      // allocate: unaligned top of the slab
      saa_pkg::S_AL_UN: begin
        alu.a   = st;
        alu.b   = fl;
        ra_d    = alu_y;
        state_d = saa_pkg::S_AL_AL;
      end
      saa_pkg::S_AL_AL: begin
        alu.a   = ra_q;
        alu.b   = mask;
        rb_d    = alu_y & ~mask;
        state_d = saa_pkg::S_AL_PAD;
      end
      saa_pkg::S_AL_PAD: begin
        alu.a   = rb_q;
        alu.b   = ra_q;
        alu.sub = 1'b1;
        rc_d    = alu_y;
        state_d = saa_pkg::S_AL_NEED;
      end
      saa_pkg::S_AL_NEED: begin
        alu.a   = sz;
        alu.b   = rc_q;
        rc_d    = alu_y;
        state_d = saa_pkg::S_AL_REM;
      end
      saa_pkg::S_AL_REM: begin
        alu.a   = cap;
        alu.b   = fl;
        alu.sub = 1'b1;
        rd_d    = alu_y;
        state_d = saa_pkg::S_AL_CMP;
      end
      saa_pkg::S_AL_CMP: begin
        alu.a   = rd_q;
        alu.b   = rc_q;
        alu.sub = 1'b1;
        state_d = alu_ge ? saa_pkg::S_AL_FNEW : saa_pkg::S_AL_SKIP;
      end
      saa_pkg::S_AL_FNEW: begin
        alu.a   = fl;
        alu.b   = rc_q;
        rd_d    = alu_y;
        state_d = saa_pkg::S_AL_TOT;
      end
      saa_pkg::S_AL_TOT: begin
        alu.a   = DW'(t_q);
        alu.b   = rc_q;
        t_d     = alu_y[saa_pkg::TOT_W-1:0];
        state_d = saa_pkg::S_AL_SWEEP;
      end
      // write back skipped slabs as full, then the target slab
      saa_pkg::S_AL_SWEEP: begin
        tw.we_fill = 1'b1;
        if (sw_q == w_q) begin
          tw.fill   = rd_q[saa_pkg::FILL_W-1:0];
          tot_d     = t_q;
          cur_d     = w_q;
          res_d.addr = rb_q[saa_pkg::ADDR_W-1:0];
          if (realloc_q) begin
            res_d.moved    = 1'b1;
            res_d.copy_len = (req_q.size < req_q.prev_size) ? req_q.size
                                                            : req_q.prev_size;
          end
          done_d  = 1'b1;
          state_d = saa_pkg::S_IDLE;
        end else begin
          tw.idx  = sw_q;
          tw.fill = cap[saa_pkg::FILL_W-1:0];
          sw_d    = sw_q + 1'b1;
        end
      end
      saa_pkg::S_AL_SKIP: begin
        alu.a = DW'(t_q);
        alu.b = rd_q;
        t_d   = alu_y[saa_pkg::TOT_W-1:0];
        if ((saa_pkg::CNT_W'(w_q) + 1'b1) < cnt_q) begin
          w_d     = w_q + 1'b1;
          state_d = saa_pkg::S_AL_UN;
        end else begin
          state_d = saa_pkg::S_AL_WORST;
        end
      end
      saa_pkg::S_AL_WORST: begin
        alu.a   = sz;
        alu.b   = mask;
        ra_d    = alu_y;
        state_d = saa_pkg::S_AL_UNITS;
      end
      saa_pkg::S_AL_UNITS: begin
        alu.a   = ra_q;
        alu.b   = DW'(saa_pkg::SLAB_BYTES - 1);
        ra_d    = alu_y >> saa_pkg::SB_LOG;
        state_d = saa_pkg::S_AL_POOL;
      end
      // new slab at the pool top, or give up with state untouched
      saa_pkg::S_AL_POOL: begin
        alu.a = DW'(pnu_q);
        alu.b = ra_q;
        if (cnt_q == saa_pkg::CNT_W'(saa_pkg::MAX_SLABS) ||
            alu_y > DW'(saa_pkg::POOL_UNITS)) begin
          res_d.status = saa_pkg::STS_EXHAUST;
          done_d       = 1'b1;
          state_d      = saa_pkg::S_IDLE;
        end else begin
          tw.idx     = w_q + 1'b1;
          tw.we_slab = 1'b1;
          tw.base    = pnu_q;
          tw.units   = ra_q[saa_pkg::UNIT_W-1:0];
          tw.we_fill = 1'b1;
          tw.fill    = '0;
          pnu_d      = alu_y[saa_pkg::UNIT_W-1:0];
          cnt_d      = cnt_q + 1'b1;
          w_d        = w_q + 1'b1;
          state_d    = saa_pkg::S_AL_UN;
        end
      end

      // deallocate: only the topmost block
      saa_pkg::S_DA_TOP: begin
        alu.a   = st;
        alu.b   = fl;
        ra_d    = alu_y;
        state_d = saa_pkg::S_DA_END;
      end
      saa_pkg::S_DA_END: begin
        alu.a   = blk;
        alu.b   = sz;
        rb_d    = alu_y;
        state_d = saa_pkg::S_DA_FS;
      end
      saa_pkg::S_DA_FS: begin
        alu.a   = fl;
        alu.b   = sz;
        alu.sub = 1'b1;
        rc_d    = alu_y;
        ge1_d   = alu_ge;
        state_d = saa_pkg::S_DA_TOT;
      end
      saa_pkg::S_DA_TOT: begin
        alu.a   = DW'(tot_q);
        alu.b   = sz;
        alu.sub = 1'b1;
        if (ra_q == rb_q && ge1_q) begin
          tw.we_fill = 1'b1;
          tw.fill    = rc_q[saa_pkg::FILL_W-1:0];
          tot_d      = alu_y[saa_pkg::TOT_W-1:0];
        end
        done_d  = 1'b1;
        state_d = saa_pkg::S_IDLE;
      end

      // reallocate: in place, keep, or fall into allocate
      saa_pkg::S_RA_TOP: begin
        alu.a   = st;
        alu.b   = fl;
        ra_d    = alu_y;
        state_d = saa_pkg::S_RA_END;
      end
      saa_pkg::S_RA_END: begin
        alu.a   = blk;
        alu.b   = osz;
        rb_d    = alu_y;
        state_d = saa_pkg::S_RA_FO;
      end
      saa_pkg::S_RA_FO: begin
        alu.a   = fl;
        alu.b   = osz;
        alu.sub = 1'b1;
        rc_d    = alu_y;
        ge1_d   = alu_ge;
        state_d = saa_pkg::S_RA_NF;
      end
      saa_pkg::S_RA_NF: begin
        alu.a   = rc_q;
        alu.b   = sz;
        rc_d    = alu_y;
        state_d = saa_pkg::S_RA_CAP;
      end
      saa_pkg::S_RA_CAP: begin
        alu.a   = cap;
        alu.b   = rc_q;
        alu.sub = 1'b1;
        ge2_d   = alu_ge;
        state_d = saa_pkg::S_RA_TOT;
      end
      saa_pkg::S_RA_TOT: begin
        alu.a   = DW'(tot_q);
        alu.b   = osz;
        alu.sub = 1'b1;
        rd_d    = alu_y;
        state_d = saa_pkg::S_RA_TOT2;
      end
      saa_pkg::S_RA_TOT2: begin
        alu.a = rd_q;
        alu.b = sz;
        if (aligned && ra_q == rb_q && ge1_q && ge2_q) begin
          tw.we_fill = 1'b1;
          tw.fill    = rc_q[saa_pkg::FILL_W-1:0];
          tot_d      = alu_y[saa_pkg::TOT_W-1:0];
          res_d.addr = req_q.block_addr;
          done_d     = 1'b1;
          state_d    = saa_pkg::S_IDLE;
        end else if (aligned && req_q.size < req_q.prev_size) begin
          res_d.addr = req_q.block_addr;
          done_d     = 1'b1;
          state_d    = saa_pkg::S_IDLE;
        end else begin
          realloc_d = 1'b1;
          state_d   = saa_pkg::S_AL_UN;
        end
      end

      // reset to mark: walk slabs back
      saa_pkg::S_RS_REM: begin
        alu.a   = DW'(tot_q);
        alu.b   = DW'(req_q.mark);
        alu.sub = 1'b1;
        first_d = 1'b0;
        ra_d    = alu_y;
        if (first_q && !alu_ge) begin
          res_d.status = saa_pkg::STS_MARK;
          done_d       = 1'b1;
          state_d      = saa_pkg::S_IDLE;
        end else begin
          state_d = saa_pkg::S_RS_CMP;
        end
      end
      saa_pkg::S_RS_CMP: begin
        alu.a   = fl;
        alu.b   = ra_q;
        alu.sub = 1'b1;
        if (alu_ge) begin
          tw.we_fill = 1'b1;
          tw.fill    = alu_y[saa_pkg::FILL_W-1:0];
          tot_d      = req_q.mark;
          cur_d      = w_q;
          done_d     = 1'b1;
          state_d    = saa_pkg::S_IDLE;
        end else begin
          state_d = saa_pkg::S_RS_DROP;
        end
      end
      saa_pkg::S_RS_DROP: begin
        alu.a      = DW'(tot_q);
        alu.b      = fl;
        alu.sub    = 1'b1;
        tw.we_fill = 1'b1;
        tw.fill    = '0;
        tot_d      = alu_y[saa_pkg::TOT_W-1:0];
        if (w_q == '0) begin
          tot_d        = '0;
          cur_d        = '0;
          res_d.status = saa_pkg::STS_MARK;
          done_d       = 1'b1;
          state_d      = saa_pkg::S_IDLE;
        end else begin
          w_d     = w_q - 1'b1;
          cur_d   = w_q - 1'b1;
          state_d = saa_pkg::S_RS_REM;
        end
      end

      // trim: drop slabs above the current one
      saa_pkg::S_TRIM: begin
        alu.a   = DW'(rd.base);
        alu.b   = DW'(rd.units);
        pnu_d   = alu_y[saa_pkg::UNIT_W-1:0];
        cnt_d   = saa_pkg::CNT_W'(cur_q) + 1'b1;
        done_d  = 1'b1;
        state_d = saa_pkg::S_IDLE;
      end

      default: begin
        state_d = saa_pkg::S_IDLE;
      end
    endcase

    // the reported total is the one left after the command
    if (done_d) begin
      res_d.total_fill = tot_d;
    end
  end

  assign busy   = (state_q != saa_pkg::S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not start work");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= saa_pkg::CNT_W'(saa_pkg::MAX_SLABS)))
    else $error("slab count out of range");
  a_cur_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saa_pkg::CNT_W'(cur_q) < cnt_q) else $error("current slab beyond table");
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnu_q <= saa_pkg::UNIT_W'(saa_pkg::POOL_UNITS)) else $error("pool overrun");
`endif

endmodule

`default_nettype wire
